// ===== hdl/ttb_pkg.sv =====
package ttb_pkg;

    // Q16.16 data word, edge and UV delta widths
    localparam int DATA_W  = 32;
    localparam int DELTA_W = DATA_W + 1;
    localparam int PROD_W  = 2 * DELTA_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int FRAC_W  = 16;
    localparam int CFG_IDX_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_USE_PLANAR_UV = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANAR_SCALE  = 8'd1;
    localparam logic [DATA_W-1:0]    PLANAR_SCALE_ONE  = 32'h0001_0000;

    // triangle queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef logic signed [DELTA_W-1:0] delta_t;

    typedef struct packed {
        delta_t e1_x;
        delta_t e1_y;
        delta_t e1_z;
        delta_t e2_x;
        delta_t e2_y;
        delta_t e2_z;
        delta_t du1;
        delta_t dv1;
        delta_t du2;
        delta_t dv2;
    } tri_t;

endpackage

// ===== hdl/ttb_queue.sv =====
module ttb_queue
    import ttb_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  tri_t push_data,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output tri_t pop_data
);

    tri_t                slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign full      = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    // store pushed triangles
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/ttb_front.sv =====
module ttb_front
    import ttb_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     use_planar_uv,
    input  logic signed [DATA_W-1:0] planar_scale,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_pos_x,
    input  logic signed [DATA_W-1:0] s_pos_y,
    input  logic signed [DATA_W-1:0] s_pos_z,
    input  logic signed [DATA_W-1:0] s_tex_u,
    input  logic signed [DATA_W-1:0] s_tex_v,
    output logic                     push,
    output tri_t                     push_data,
    input  logic                     full
);

    localparam logic [1:0] CORNER_FIRST  = 2'd0;
    localparam logic [1:0] CORNER_SECOND = 2'd1;
    localparam logic [1:0] CORNER_THIRD  = 2'd2;

    localparam int SH_W = 2 * DATA_W - FRAC_W;
    localparam logic signed [SH_W-1:0] UV_MAX = SH_W'(64'sh7FFF_FFFF);
    localparam logic signed [SH_W-1:0] UV_MIN = -SH_W'(64'sh8000_0000);

    function automatic logic signed [DATA_W-1:0] scale_to_uv(
        input logic signed [2*DATA_W-1:0] p);
        logic signed [SH_W-1:0] s;
        s = p[2*DATA_W-1:FRAC_W];
        if (s > UV_MAX) begin
            return DATA_W'(UV_MAX);
        end else if (s < UV_MIN) begin
            return DATA_W'(UV_MIN);
        end
        return DATA_W'(s);
    endfunction

    function automatic delta_t diff(input logic signed [DATA_W-1:0] a,
                                    input logic signed [DATA_W-1:0] b);
        return delta_t'($signed({a[DATA_W-1], a}) - $signed({b[DATA_W-1], b}));
    endfunction

    logic                       s1_valid_reg;
    logic                       s1_planar_reg;
    logic signed [DATA_W-1:0]   s1_x_reg, s1_y_reg, s1_z_reg, s1_u_reg, s1_v_reg;
    logic signed [2*DATA_W-1:0] s1_px_reg, s1_pz_reg;
    logic [1:0]                 corner_reg;
    logic signed [DATA_W-1:0]   c0_x_reg, c0_y_reg, c0_z_reg, c0_u_reg, c0_v_reg;
    logic signed [DATA_W-1:0]   c1_x_reg, c1_y_reg, c1_z_reg, c1_u_reg, c1_v_reg;
    logic signed [DATA_W-1:0]   uv_u, uv_v;
    logic                       advance;

    // effective UV of the staged vertex
    assign uv_u = s1_planar_reg ? scale_to_uv(s1_px_reg) : s1_u_reg;
    assign uv_v = s1_planar_reg ? scale_to_uv(s1_pz_reg) : s1_v_reg;

    assign advance = s1_valid_reg && !((corner_reg == CORNER_THIRD) && full);
    assign s_ready = !s1_valid_reg || advance;
    assign push    = s1_valid_reg && (corner_reg == CORNER_THIRD) && !full;

    // form edges and UV deltas on the closing corner
    always_comb begin
        push_data.e1_x = diff(c1_x_reg, c0_x_reg);
        push_data.e1_y = diff(c1_y_reg, c0_y_reg);
        push_data.e1_z = diff(c1_z_reg, c0_z_reg);
        push_data.e2_x = diff(s1_x_reg, c0_x_reg);
        push_data.e2_y = diff(s1_y_reg, c0_y_reg);
        push_data.e2_z = diff(s1_z_reg, c0_z_reg);
        push_data.du1  = diff(c1_u_reg, c0_u_reg);
        push_data.dv1  = diff(c1_v_reg, c0_v_reg);
        push_data.du2  = diff(uv_u, c0_u_reg);
        push_data.dv2  = diff(uv_v, c0_v_reg);
    end

    // stage the accepted beat with its planar products
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_x_reg      <= s_pos_x;
            s1_y_reg      <= s_pos_y;
            s1_z_reg      <= s_pos_z;
            s1_u_reg      <= s_tex_u;
            s1_v_reg      <= s_tex_v;
            s1_planar_reg <= use_planar_uv;
            s1_px_reg     <= s_pos_x * planar_scale;
            s1_pz_reg     <= s_pos_z * planar_scale;
        end
    end

    // hold the first two corners
    always_ff @(posedge aclk) begin
        if (advance && corner_reg == CORNER_FIRST) begin
            c0_x_reg <= s1_x_reg;
            c0_y_reg <= s1_y_reg;
            c0_z_reg <= s1_z_reg;
            c0_u_reg <= uv_u;
            c0_v_reg <= uv_v;
        end
        if (advance && corner_reg == CORNER_SECOND) begin
            c1_x_reg <= s1_x_reg;
            c1_y_reg <= s1_y_reg;
            c1_z_reg <= s1_z_reg;
            c1_u_reg <= uv_u;
            c1_v_reg <= uv_v;
        end
    end

    // track stage occupancy and corner position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            corner_reg   <= CORNER_FIRST;
        end else begin
            if (s_valid && s_ready) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                corner_reg <= (corner_reg == CORNER_THIRD) ? CORNER_FIRST
                                                           : corner_reg + 2'd1;
            end
        end
    end

endmodule

// ===== hdl/ttb_back.sv =====
module ttb_back
    import ttb_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    input  tri_t                     q_data,
    output logic                     q_pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_tangent_x,
    output logic signed [DATA_W-1:0] m_tangent_y,
    output logic signed [DATA_W-1:0] m_tangent_z,
    output logic signed [DATA_W-1:0] m_bitangent_x,
    output logic signed [DATA_W-1:0] m_bitangent_y,
    output logic signed [DATA_W-1:0] m_bitangent_z,
    output logic                     m_degenerate,
    output logic                     m_saturated
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    localparam int NACC  = 7;
    localparam int NRES  = 6;
    localparam int MAG_W = ACC_W;
    localparam int NW    = MAG_W + FRAC_W + 2;
    localparam int DW    = MAG_W + 1;
    localparam int RW    = DW + 1;
    localparam int CNT_W = $clog2(NW + 1);
    localparam logic [3:0] MUL_LAST = 4'd13;
    localparam logic [3:0] MUL_DONE = 4'd15;
    localparam logic [2:0] COMP_FIRST = 3'd1;
    localparam logic [2:0] COMP_LAST  = 3'd6;
    localparam logic [DATA_W-1:0] LIM_POS = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] LIM_NEG = 32'h8000_0000;

    state_t                    state_reg;
    tri_t                      job_reg;
    logic [3:0]                k_reg;
    logic                      pv_reg;
    logic [3:0]                pk_reg;
    logic signed [PROD_W-1:0]  p_reg;
    logic signed [ACC_W-1:0]   acc_reg [NACC];
    logic [2:0]                comp_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [NW-1:0]             n_reg;
    logic [DW-1:0]             d_reg;
    logic [RW-1:0]             rem_reg;
    logic [DATA_W-1:0]         q_reg;
    logic                      ovf_reg;
    logic                      neg_reg;
    logic [DATA_W-1:0]         res_reg [NRES];
    logic                      sat_reg;
    logic                      deg_reg;
    logic                      out_valid_reg;
    logic [DATA_W-1:0]         out_reg [NRES];
    logic                      out_deg_reg, out_sat_reg;

    delta_t                    op_a, op_b;
    logic [2:0]                ld_idx;
    logic signed [ACC_W-1:0]   ld_num, det;
    logic [MAG_W-1:0]          ld_mn, ld_md;
    logic [RW-1:0]             rem_sh;
    logic                      ge;
    logic [DATA_W-1:0]         limit, mag, comp_val;
    logic                      comp_sat;
    logic                      out_free;

    // pick the operands of the product in flight
    always_comb begin
        unique case (k_reg)
            4'd0:    begin op_a = job_reg.du1;  op_b = job_reg.dv2; end
            4'd1:    begin op_a = job_reg.dv1;  op_b = job_reg.du2; end
            4'd2:    begin op_a = job_reg.e1_x; op_b = job_reg.dv2; end
            4'd3:    begin op_a = job_reg.e2_x; op_b = job_reg.dv1; end
            4'd4:    begin op_a = job_reg.e1_y; op_b = job_reg.dv2; end
            4'd5:    begin op_a = job_reg.e2_y; op_b = job_reg.dv1; end
            4'd6:    begin op_a = job_reg.e1_z; op_b = job_reg.dv2; end
            4'd7:    begin op_a = job_reg.e2_z; op_b = job_reg.dv1; end
            4'd8:    begin op_a = job_reg.e2_x; op_b = job_reg.du1; end
            4'd9:    begin op_a = job_reg.e1_x; op_b = job_reg.du2; end
            4'd10:   begin op_a = job_reg.e2_y; op_b = job_reg.du1; end
            4'd11:   begin op_a = job_reg.e1_y; op_b = job_reg.du2; end
            4'd12:   begin op_a = job_reg.e2_z; op_b = job_reg.du1; end
            4'd13:   begin op_a = job_reg.e1_z; op_b = job_reg.du2; end
            default: begin op_a = '0;           op_b = '0;           end
        endcase
    end

    // set up the divider for the next component
    assign det    = acc_reg[0];
    assign ld_idx = (state_reg == ST_MUL) ? COMP_FIRST : comp_reg + 3'd1;
    assign ld_num = acc_reg[ld_idx];
    assign ld_mn  = ld_num[ACC_W-1] ? MAG_W'(-ld_num) : MAG_W'(ld_num);
    assign ld_md  = det[ACC_W-1] ? MAG_W'(-det) : MAG_W'(det);

    // one restoring step
    assign rem_sh = {rem_reg[RW-2:0], n_reg[NW-1]};
    assign ge     = (rem_sh >= RW'(d_reg));

    // clamp and sign the finished (already rounded) quotient
    assign limit    = neg_reg ? LIM_NEG : LIM_POS;
    assign comp_sat = ovf_reg || (q_reg > limit);
    assign mag      = comp_sat ? limit : q_reg;
    assign comp_val = neg_reg ? -mag : mag;

    assign out_free = !out_valid_reg || m_ready;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;

    // datapath
    always_ff @(posedge aclk) begin
        p_reg  <= op_a * op_b;
        pk_reg <= k_reg;
        if (q_pop) begin
            job_reg <= q_data;
        end
        if (pv_reg) begin
            if (pk_reg[0]) begin
                acc_reg[pk_reg[3:1]] <= acc_reg[pk_reg[3:1]] - ACC_W'(p_reg);
            end else begin
                acc_reg[pk_reg[3:1]] <= ACC_W'(p_reg);
            end
        end
        if ((state_reg == ST_MUL && k_reg == MUL_DONE)
            || (state_reg == ST_DIV && cnt_reg == CNT_W'(NW))) begin
            n_reg   <= NW'({ld_mn, {FRAC_W + 1{1'b0}}}) + NW'(ld_md);
            d_reg   <= {ld_md, 1'b0};
            neg_reg <= ld_num[ACC_W-1] ^ det[ACC_W-1];
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end else if (state_reg == ST_DIV) begin
            n_reg   <= {n_reg[NW-2:0], 1'b0};
            rem_reg <= ge ? rem_sh - RW'(d_reg) : rem_sh;
            q_reg   <= {q_reg[DATA_W-2:0], ge};
            ovf_reg <= ovf_reg | q_reg[DATA_W-1];
        end
        if (state_reg == ST_DIV && cnt_reg == CNT_W'(NW)) begin
            res_reg[comp_reg - 3'd1] <= comp_val;
        end
        if (state_reg == ST_MUL && k_reg == MUL_DONE && det == '0) begin
            for (int i = 0; i < NRES; i++) begin
                res_reg[i] <= '0;
            end
        end
        if (state_reg == ST_FIN && out_free) begin
            for (int i = 0; i < NRES; i++) begin
                out_reg[i] <= res_reg[i];
            end
            out_deg_reg <= deg_reg;
            out_sat_reg <= sat_reg;
        end
    end

    // sequence products, divisions and hand-off
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            pv_reg        <= 1'b0;
            comp_reg      <= '0;
            cnt_reg       <= '0;
            sat_reg       <= 1'b0;
            deg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            // load a new result beat, or drop the one taken
            if (state_reg == ST_FIN && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            pv_reg <= (state_reg == ST_MUL) && (k_reg <= MUL_LAST);
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        k_reg     <= '0;
                        sat_reg   <= 1'b0;
                        deg_reg   <= 1'b0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (k_reg == MUL_DONE) begin
                        if (det == '0) begin
                            deg_reg   <= 1'b1;
                            state_reg <= ST_FIN;
                        end else begin
                            comp_reg  <= COMP_FIRST;
                            cnt_reg   <= '0;
                            state_reg <= ST_DIV;
                        end
                    end else begin
                        k_reg <= k_reg + 4'd1;
                    end
                end
                ST_DIV: begin
                    if (cnt_reg == CNT_W'(NW)) begin
                        sat_reg <= sat_reg | comp_sat;
                        cnt_reg <= '0;
                        if (comp_reg == COMP_LAST) begin
                            state_reg <= ST_FIN;
                        end else begin
                            comp_reg <= comp_reg + 3'd1;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_tangent_x   = out_reg[0];
    assign m_tangent_y   = out_reg[1];
    assign m_tangent_z   = out_reg[2];
    assign m_bitangent_x = out_reg[3];
    assign m_bitangent_y = out_reg[4];
    assign m_bitangent_z = out_reg[5];
    assign m_degenerate  = out_deg_reg;
    assign m_saturated   = out_sat_reg;

endmodule

// ===== hdl/triangle_tangent_bitangent.sv =====
// Vertices are taken one a cycle until the two-entry triangle queue fills.
// The back end takes one triangle at a time: it pops it, forms the fourteen
// products on the shared 33x33 multiplier and, unless the determinant is zero,
// runs six divisions on the bit-serial divider, one quotient bit a cycle, before
// it hands off the result. Reset (aresetn low, synchronous) empties the pipeline,
// restarts at the first corner and restores UV mode off, scale 1.0.
module triangle_tangent_bitangent
    import ttb_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [DATA_W-1:0]           cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [DATA_W-1:0]    s_pos_x,
    input  logic signed [DATA_W-1:0]    s_pos_y,
    input  logic signed [DATA_W-1:0]    s_pos_z,
    input  logic signed [DATA_W-1:0]    s_tex_u,
    input  logic signed [DATA_W-1:0]    s_tex_v,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [DATA_W-1:0]    m_tangent_x,
    output logic signed [DATA_W-1:0]    m_tangent_y,
    output logic signed [DATA_W-1:0]    m_tangent_z,
    output logic signed [DATA_W-1:0]    m_bitangent_x,
    output logic signed [DATA_W-1:0]    m_bitangent_y,
    output logic signed [DATA_W-1:0]    m_bitangent_z,
    output logic                        m_degenerate,
    output logic                        m_saturated
);

    logic                     use_planar_uv_reg;
    logic signed [DATA_W-1:0] planar_scale_reg;
    logic                     push, full, q_valid, q_pop;
    tri_t                     push_data, q_data;

    assign cfg_ready = 1'b1;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_planar_uv_reg <= 1'b0;
            planar_scale_reg  <= PLANAR_SCALE_ONE;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_USE_PLANAR_UV) begin
                use_planar_uv_reg <= cfg_data[0];
            end else if (cfg_index == REG_PLANAR_SCALE) begin
                planar_scale_reg <= cfg_data;
            end
        end
    end

    ttb_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .use_planar_uv (use_planar_uv_reg),
        .planar_scale  (planar_scale_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_pos_z       (s_pos_z),
        .s_tex_u       (s_tex_u),
        .s_tex_v       (s_tex_v),
        .push          (push),
        .push_data     (push_data),
        .full          (full)
    );

    ttb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    ttb_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tangent_x   (m_tangent_x),
        .m_tangent_y   (m_tangent_y),
        .m_tangent_z   (m_tangent_z),
        .m_bitangent_x (m_bitangent_x),
        .m_bitangent_y (m_bitangent_y),
        .m_bitangent_z (m_bitangent_z),
        .m_degenerate  (m_degenerate),
        .m_saturated   (m_saturated)
    );

endmodule
